[hw/rtl/rf3_pkg.sv]
// shared types, constants and register codes for the 3x3 rank filter
package rf3_pkg;

   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int PIXEL_BITS_DEF = 8;

   localparam int WIN_SIZE = 9;
   localparam int MIN_IDX  = 0;
   localparam int MED_IDX  = 4;
   localparam int MAX_IDX  = 8;

   localparam int CFG_WIDTH_BITS  = 12;
   localparam int CFG_HEIGHT_BITS = 16;
   localparam int ROW_BITS        = CFG_HEIGHT_BITS + 1;
   localparam int CSR_INDEX_BITS  = 1;
   localparam int CSR_DATA_BITS   = 16;

   localparam logic [CFG_WIDTH_BITS-1:0]  WIDTH_RESET  = 12'd640;
   localparam logic [CFG_HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd480;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } opcode_type;

   // per-transaction control carried from the input register to the window stage
   typedef struct packed {
      logic col0;
      logic up_en;
      logic lo_en;
      logic emit;
      logic last;
   } ctl_type;

endpackage

[hw/rtl/rf3_rank.sv]
// nine-input sorting network giving minimum, median and maximum
module rf3_rank
   import rf3_pkg::*;
#(
   parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
   input  logic [PIXEL_BITS-1:0] hood [WIN_SIZE],
   output logic [PIXEL_BITS-1:0] med_value,
   output logic [PIXEL_BITS-1:0] max_value,
   output logic [PIXEL_BITS-1:0] min_value
);

   logic [PIXEL_BITS-1:0] s [WIN_SIZE];

   // odd-even transposition sort, one compare-exchange layer per pass
   always_comb begin
      logic [PIXEL_BITS-1:0] t;
      t = '0;
      for (int k = 0; k < WIN_SIZE; k++) begin
         s[k] = hood[k];
      end
      for (int p = 0; p < WIN_SIZE; p++) begin
         for (int i = p % 2; i + 1 < WIN_SIZE; i += 2) begin
            if (s[i] > s[i+1]) begin
               t      = s[i];
               s[i]   = s[i+1];
               s[i+1] = t;
            end
         end
      end
   end

   assign min_value = s[MIN_IDX];
   assign med_value = s[MED_IDX];
   assign max_value = s[MAX_IDX];

endmodule

[hw/rtl/rank_filter_3x3.sv]
// top level of the 3x3 median / maximum / minimum filter
//
//  channel | direction | ports                                     | transfer
//  req     | in        | req_opcode, req_pixel                     | req_valid & req_ready
//  rsp     | out       | rsp_median/max/min_value, last_of_frame   | rsp_valid & rsp_ready
//  csr     | in        | csr_index, csr_data                       | csr_valid & csr_ready
//
// one pixel per clock while req_ready is high; a result passes from its taken transaction through
// the input register with line store read, then window and sort into the output register
// the first width+1 transactions of a frame give no result
// rsp stalls hold the output register; req_ready drops only while a result waits
// there and the window stage also holds one; csr is always ready
// reset clears control state; the line stores need no clearing pass
module rank_filter_3x3
   import rf3_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_opcode,
   input  logic [PIXEL_BITS-1:0]     req_pixel,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [PIXEL_BITS-1:0]     rsp_median_value,
   output logic [PIXEL_BITS-1:0]     rsp_max_value,
   output logic [PIXEL_BITS-1:0]     rsp_min_value,
   output logic                      rsp_last_of_frame,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = ($clog2(MAX_WIDTH + 1) > CFG_WIDTH_BITS) ?
                       $clog2(MAX_WIDTH + 1) : CFG_WIDTH_BITS;
   localparam logic [CW-1:0] MAXW = CW'(MAX_WIDTH);

   function automatic logic [CW-1:0] clamp_width(input logic [CFG_WIDTH_BITS-1:0] raw);
      logic [CW-1:0] ext;
      ext = CW'(raw);
      if (ext == '0) begin
         return CW'(1);
      end else if (ext > MAXW) begin
         return MAXW;
      end else begin
         return ext;
      end
   endfunction

   function automatic logic [CFG_HEIGHT_BITS-1:0] clamp_height(
      input logic [CFG_HEIGHT_BITS-1:0] raw);
      if (raw == '0) begin
         return CFG_HEIGHT_BITS'(1);
      end else begin
         return raw;
      end
   endfunction

   // configuration
   logic [CW-1:0]              width_ff;
   logic [CFG_HEIGHT_BITS-1:0] height_ff;
   logic                       csr_fire;

   // position counters
   logic [AW-1:0]       col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [CW-1:0]       col_inc;
   logic                req_fire;

   // input register stage
   logic                  a_valid_ff;
   logic [AW-1:0]         a_col_ff;
   logic [PIXEL_BITS-1:0] a_pix_ff;
   ctl_type               a_ctl_ff, ctl_in;
   logic [PIXEL_BITS-1:0] up_rd_ff, lo_rd_ff;
   logic                  a_adv;

   // line stores
   logic [PIXEL_BITS-1:0] upper_mem [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] lower_mem [MAX_WIDTH];

   // window
   logic [PIXEL_BITS-1:0] win_ff [WIN_SIZE];
   logic [PIXEL_BITS-1:0] win_in [WIN_SIZE];
   logic [PIXEL_BITS-1:0] hood [WIN_SIZE];
   logic [PIXEL_BITS-1:0] up_val, lo_val;
   logic [PIXEL_BITS-1:0] med_w, max_w, min_w;

   // output register
   logic                  rsp_valid_ff;
   logic [PIXEL_BITS-1:0] med_ff, max_ff, min_ff;
   logic                  last_ff;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;

   assign a_adv     = a_valid_ff & (~a_ctl_ff.emit | ~rsp_valid_ff | rsp_ready);
   assign req_ready = ~a_valid_ff | a_adv;
   assign req_fire  = req_valid & req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= clamp_width(WIDTH_RESET);
         height_ff <= HEIGHT_RESET;
      end else if (csr_fire) begin
         case (csr_index)
            REG_FRAME_WIDTH: begin
               width_ff <= clamp_width(csr_data[CFG_WIDTH_BITS-1:0]);
            end
            REG_FRAME_HEIGHT: begin
               height_ff <= clamp_height(csr_data[CFG_HEIGHT_BITS-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   // position decode for the incoming transaction
   always_comb begin
      col_inc      = CW'(col_ff) + CW'(1);
      ctl_in.col0  = (col_ff == '0);
      ctl_in.up_en = (row_ff >= ROW_BITS'(2));
      ctl_in.lo_en = (row_ff != '0);
      ctl_in.emit  = (row_ff >= ROW_BITS'(2)) | ((row_ff == ROW_BITS'(1)) & (col_ff != '0));
      ctl_in.last  = (row_ff == ({1'b0, height_ff} + ROW_BITS'(1)));
      if (ctl_in.last) begin
         col_in = '0;
         row_in = '0;
      end else if (col_inc >= width_ff) begin
         col_in = '0;
         row_in = row_ff + ROW_BITS'(1);
      end else begin
         col_in = col_inc[AW-1:0];
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_fire) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_fire) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_fire) begin
         a_valid_ff <= 1'b1;
      end else if (a_adv) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_col_ff <= col_ff;
         a_ctl_ff <= ctl_in;
         a_pix_ff <= ((req_opcode == OP_PIXEL) && (row_ff < {1'b0, height_ff})) ?
                     req_pixel : '0;
      end
   end

   assign up_val = a_ctl_ff.up_en ? up_rd_ff : '0;
   assign lo_val = a_ctl_ff.lo_en ? lo_rd_ff : '0;

   // write back happens as the window stage retires; a read of the same column
   // in that cycle (single-column frames) takes the new data
   always_ff @(posedge clock) begin
      if (a_adv) begin
         upper_mem[a_col_ff] <= lo_val;
      end
      if (req_fire) begin
         up_rd_ff <= (a_adv && (a_col_ff == col_ff)) ? lo_val : upper_mem[col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv) begin
         lower_mem[a_col_ff] <= a_pix_ff;
      end
      if (req_fire) begin
         lo_rd_ff <= (a_adv && (a_col_ff == col_ff)) ? a_pix_ff : lower_mem[col_ff];
      end
   end

   // window shift; at column zero the old right columns finish the previous row
   always_comb begin
      for (int k = 0; k < WIN_SIZE - 3; k++) begin
         win_in[k] = a_ctl_ff.col0 ? '0 : win_ff[k+3];
         hood[k]   = a_ctl_ff.col0 ? win_ff[k+3] : win_ff[k+3];
      end
      win_in[6] = up_val;
      win_in[7] = lo_val;
      win_in[8] = a_pix_ff;
      for (int k = WIN_SIZE - 3; k < WIN_SIZE; k++) begin
         hood[k] = a_ctl_ff.col0 ? '0 : win_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_fire) begin
         for (int k = 0; k < WIN_SIZE; k++) begin
            win_ff[k] <= '0;
         end
      end else if (a_adv) begin
         for (int k = 0; k < WIN_SIZE; k++) begin
            win_ff[k] <= a_ctl_ff.last ? '0 : win_in[k];
         end
      end
   end

   rf3_rank #(
      .PIXEL_BITS(PIXEL_BITS)
   ) u_rank (
      .hood      (hood),
      .med_value (med_w),
      .max_value (max_w),
      .min_value (min_w)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (a_adv && a_ctl_ff.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv && a_ctl_ff.emit) begin
         med_ff  <= med_w;
         max_ff  <= max_w;
         min_ff  <= min_w;
         last_ff <= a_ctl_ff.last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_median_value  = med_ff;
   assign rsp_max_value     = max_ff;
   assign rsp_min_value     = min_ff;
   assign rsp_last_of_frame = last_ff;

endmodule

[hw/rtl/rf3_checker.sv]
// port-level checks for the 3x3 rank filter, bound to the top level
module rf3_checker
   import rf3_pkg::*;
#(
   parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [PIXEL_BITS-1:0] rsp_median_value,
   input logic [PIXEL_BITS-1:0] rsp_max_value,
   input logic [PIXEL_BITS-1:0] rsp_min_value
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // ranks are ordered
   a_rank_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_min_value <= rsp_median_value) &&
                    (rsp_median_value <= rsp_max_value))
      else $error("min/median/max out of order");

   // a new result follows an input transaction that passed the input register and the output register
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a matching input transaction");

   // input back-pressure only comes from a stalled output
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output back-pressure");

endmodule

bind rank_filter_3x3 rf3_checker #(
   .PIXEL_BITS(PIXEL_BITS)
) u_rf3_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_median_value (rsp_median_value),
   .rsp_max_value    (rsp_max_value),
   .rsp_min_value    (rsp_min_value)
);
